// ===== rtl/core/nibble_framebuffer_block_move_assert.svh =====
// ----------------------------------------------------------------------------
// nibble_framebuffer_block_move_assert.svh
// Assertion macros shared by the framebuffer block-move modules. Each
// macro expects a clock named clk and a synchronous reset named rst.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_FRAMEBUFFER_BLOCK_MOVE_ASSERT_SVH
`define NIBBLE_FRAMEBUFFER_BLOCK_MOVE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define NFB_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A property whose consequence must hold in the cycle after its antecedent.
`define NFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/nfb_pkg.sv =====
// ----------------------------------------------------------------------------
// nfb_pkg
// Shared types and constants of the nibble framebuffer block-move engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nfb_pkg;

  // Field widths of the bus and configuration words.
  localparam int DATA_W      = 8;
  localparam int NIB_W       = 4;
  localparam int BYTE_ADDR_W = 14;
  localparam int COORD_W     = 10;
  localparam int PITCH_W     = 11;
  localparam int SHIFT_W     = 11;
  localparam int STRIDE_W    = 11;
  localparam int CNT_W       = 11;
  localparam int SPAN_W      = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  // Nibble handling within a packed byte.
  localparam logic [DATA_W-1:0] NIB_HI_MASK = 8'hf0;
  localparam logic [DATA_W-1:0] NIB_LO_MASK = 8'h0f;
  localparam int                NIB_SHIFT   = 4;

  // Reset value of the pitch register.
  localparam logic [PITCH_W-1:0] PITCH_RESET = 11'd320;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_MOVE  = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH   = 3'd0,
    CFG_LEFT    = 3'd1,
    CFG_TOP     = 3'd2,
    CFG_RIGHT   = 3'd3,
    CFG_BOTTOM  = 3'd4,
    CFG_SHIFT_X = 3'd5,
    CFG_SHIFT_Y = 3'd6
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_MV_CHECK,
    S_MV_ADDR,
    S_MV_RSRC,
    S_MV_RDST,
    S_MV_WR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic bus_wr;
    logic bus_rd;
    logic mv_init;
    logic mv_addr;
    logic mv_rsrc;
    logic mv_rdst;
    logic mv_wr;
    logic res_imm;
    logic res_imm_done;
    logic res_rd;
    logic res_mv;
  } nfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
    logic out_busy;
    logic mv_empty;
    logic mv_last;
  } nfb_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/nibble_framebuffer_block_move.sv =====
// Byte write: result in the output register after the accepting edge.
// Byte read: the registered memory read result is loaded in S_RD_WAIT; no new word before idle.
// Move: after a check state, each nibble copied takes address,
// source read, destination read and write back on the single-read memory.
// Reset is synchronous: state, configuration and out_valid return to defaults, memory is not cleared.
// ----------------------------------------------------------------------------
// nibble_framebuffer_block_move
// Top level of a 4-bit-per-pixel packed framebuffer with byte access and
// a rectangle move engine.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_framebuffer_block_move import nfb_pkg::*; #(
  parameter int FB_BYTES  = 16384,
  parameter int MAX_PITCH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             op,
  input  logic [BYTE_ADDR_W-1:0] byte_addr,
  input  logic [DATA_W-1:0]      write_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_W-1:0]      read_data,
  output logic                   op_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  nfb_cmd_t cmd;
  nfb_sts_t sts;

  // Controller.
  nfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath with the framebuffer memory.
  nfb_datapath #(
    .FB_BYTES  (FB_BYTES),
    .MAX_PITCH (MAX_PITCH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .byte_addr  (byte_addr),
    .write_data (write_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .op_done    (op_done)
  );

endmodule

`default_nettype wire

// ===== rtl/core/nfb_ram.sv =====
// ----------------------------------------------------------------------------
// nfb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/nfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfb_ctrl
// Controller of the block-move engine: accepts words, sequences bus
// accesses and the four-step nibble copy loop of a move.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nibble_framebuffer_block_move_assert.svh"

module nfb_ctrl import nfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  output logic       cfg_ready,
  input  nfb_sts_t   sts,
  output nfb_cmd_t   cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  // An input word is taken only in idle with room in the output register.
  assign in_stall  = !((state == S_IDLE) && !sts.out_busy);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && !in_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_READ: state_next = S_RD_WAIT;
            OP_MOVE: state_next = S_MV_CHECK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT:  state_next = S_IDLE;
      S_MV_CHECK: state_next = sts.mv_empty ? S_IDLE : S_MV_ADDR;
      S_MV_ADDR:  state_next = S_MV_RSRC;
      S_MV_RSRC:  state_next = S_MV_RDST;
      S_MV_RDST:  state_next = S_MV_WR;
      S_MV_WR:    state_next = sts.mv_last ? S_IDLE : S_MV_ADDR;
      default:    state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_WRITE: begin
              cmd.bus_wr       = 1'b1;
              cmd.res_imm      = 1'b1;
              cmd.res_imm_done = 1'b1;
            end
            OP_READ: cmd.bus_rd  = 1'b1;
            OP_MOVE: cmd.mv_init = 1'b1;
            default: cmd.res_imm = 1'b1;
          endcase
        end
      end
      S_RD_WAIT:  cmd.res_rd  = 1'b1;
      S_MV_CHECK: cmd.res_mv  = sts.mv_empty;
      S_MV_ADDR:  cmd.mv_addr = 1'b1;
      S_MV_RSRC:  cmd.mv_rsrc = 1'b1;
      S_MV_RDST:  cmd.mv_rdst = 1'b1;
      S_MV_WR: begin
        cmd.mv_wr  = 1'b1;
        cmd.res_mv = sts.mv_last;
      end
      default: cmd = '0;
    endcase
  end

  // The read and move results always land in an empty output register.
  `NFB_ASSERT(a_rd_out_empty, (state == S_RD_WAIT) |-> !sts.out_valid, "read result blocked")
  `NFB_ASSERT(a_mv_out_empty, cmd.res_mv |-> !sts.out_valid, "move result blocked")

endmodule

`default_nettype wire

// ===== rtl/core/nfb_datapath.sv =====
// ----------------------------------------------------------------------------
// nfb_datapath
// Configuration registers, move counters, pixel address generation,
// nibble merge, framebuffer memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nibble_framebuffer_block_move_assert.svh"

module nfb_datapath import nfb_pkg::*; #(
  parameter int FB_BYTES  = 16384,
  parameter int MAX_PITCH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nfb_cmd_t               cmd,
  output nfb_sts_t               sts,
  input  logic [BYTE_ADDR_W-1:0] byte_addr,
  input  logic [DATA_W-1:0]      write_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_W-1:0]      read_data,
  output logic                   op_done
);

  // FB_BYTES is a power of two, so wrapping an address keeps its low bits.
  localparam int ADDR_W = $clog2(FB_BYTES);
  localparam int PROD_W = COORD_W + STRIDE_W;
  localparam int SUM_W  = PROD_W + 1;

  // Configuration registers.
  logic        [PITCH_W-1:0] pitch;
  logic        [COORD_W-1:0] rect_left;
  logic        [COORD_W-1:0] rect_top;
  logic        [COORD_W-1:0] rect_right;
  logic        [COORD_W-1:0] rect_bottom;
  logic signed [SHIFT_W-1:0] shift_x;
  logic signed [SHIFT_W-1:0] shift_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch       <= PITCH_RESET;
      rect_left   <= '0;
      rect_top    <= '0;
      rect_right  <= '0;
      rect_bottom <= '0;
      shift_x     <= '0;
      shift_y     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PITCH:   pitch       <= cfg_data[PITCH_W-1:0];
        CFG_LEFT:    rect_left   <= cfg_data[COORD_W-1:0];
        CFG_TOP:     rect_top    <= cfg_data[COORD_W-1:0];
        CFG_RIGHT:   rect_right  <= cfg_data[COORD_W-1:0];
        CFG_BOTTOM:  rect_bottom <= cfg_data[COORD_W-1:0];
        CFG_SHIFT_X: shift_x     <= $signed(cfg_data[SHIFT_W-1:0]);
        CFG_SHIFT_Y: shift_y     <= $signed(cfg_data[SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Row stride in bytes, with the pitch saturated at its maximum.
  logic [PITCH_W-1:0]  pitch_eff;
  logic [STRIDE_W-1:0] stride;

  assign pitch_eff = (32'(pitch) > MAX_PITCH) ? PITCH_W'(MAX_PITCH) : pitch;
  assign stride    = STRIDE_W'(({1'b0, pitch_eff} + (PITCH_W + 1)'(1)) >> 1);

  // Move geometry: copy span per row and rows, start corner and direction.
  logic signed [SPAN_W-1:0] width_s;
  logic signed [SPAN_W-1:0] height_s;
  logic signed [SPAN_W-1:0] sx_e;
  logic signed [SPAN_W-1:0] sy_e;
  logic signed [SPAN_W-1:0] abs_sx;
  logic signed [SPAN_W-1:0] abs_sy;
  logic signed [SPAN_W-1:0] inner_s;
  logic signed [SPAN_W-1:0] outer_s;
  logic                     horiz;
  logic                     move_right;
  logic                     move_down;
  logic [CNT_W-1:0]         inner_init;
  logic [CNT_W-1:0]         outer_init;
  logic [COORD_W-1:0]       col_start_c;
  logic [COORD_W-1:0]       row_start_c;

  always_comb begin
    width_s     = $signed({2'b00, rect_right}) - $signed({2'b00, rect_left})
                  + SPAN_W'(1);
    height_s    = $signed({2'b00, rect_bottom}) - $signed({2'b00, rect_top})
                  + SPAN_W'(1);
    sx_e        = {shift_x[SHIFT_W-1], shift_x};
    sy_e        = {shift_y[SHIFT_W-1], shift_y};
    abs_sx      = sx_e[SPAN_W-1] ? -sx_e : sx_e;
    abs_sy      = sy_e[SPAN_W-1] ? -sy_e : sy_e;
    horiz       = (shift_x != '0);
    move_right  = horiz && !shift_x[SHIFT_W-1];
    move_down   = !horiz && (shift_y != '0) && !shift_y[SHIFT_W-1];
    inner_s     = horiz ? (width_s - abs_sx) : width_s;
    // With no shift at all the move changes nothing and copies nothing.
    outer_s     = horiz ? height_s : ((shift_y == '0) ? '0 : (height_s - abs_sy));
    inner_init  = (inner_s > 0) ? CNT_W'(inner_s) : '0;
    outer_init  = (outer_s > 0) ? CNT_W'(outer_s) : '0;
    col_start_c = move_right ? rect_right : rect_left;
    row_start_c = move_down ? rect_bottom : rect_top;
  end

  // Move walk state: destination pixel and remaining counts.
  logic [CNT_W-1:0]         inner_reload;
  logic [CNT_W-1:0]         inner_left;
  logic [CNT_W-1:0]         outer_left;
  logic [COORD_W-1:0]       col_start;
  logic                     col_dec;
  logic                     row_dec;
  logic [COORD_W-1:0]       dst_col;
  logic [COORD_W-1:0]       dst_row;
  logic [STRIDE_W-1:0]      stride_q;
  logic signed [SPAN_W-1:0] col_off;
  logic signed [SPAN_W-1:0] row_off;

  always_ff @(posedge clk) begin
    if (cmd.mv_init) begin
      inner_reload <= inner_init;
      inner_left   <= inner_init;
      outer_left   <= outer_init;
      col_start    <= col_start_c;
      col_dec      <= move_right;
      row_dec      <= move_down;
      dst_col      <= col_start_c;
      dst_row      <= row_start_c;
      stride_q     <= stride;
      col_off      <= horiz ? sx_e : '0;
      row_off      <= horiz ? '0 : sy_e;
    end else if (cmd.mv_wr) begin
      if (inner_left == CNT_W'(1)) begin
        // End of a row: back to the row start, step to the next row.
        inner_left <= inner_reload;
        dst_col    <= col_start;
        outer_left <= outer_left - CNT_W'(1);
        dst_row    <= row_dec ? (dst_row - COORD_W'(1)) : (dst_row + COORD_W'(1));
      end else begin
        inner_left <= inner_left - CNT_W'(1);
        dst_col    <= col_dec ? (dst_col - COORD_W'(1)) : (dst_col + COORD_W'(1));
      end
    end
  end

  assign sts.mv_empty = (inner_left == '0) || (outer_left == '0);
  assign sts.mv_last  = (inner_left == CNT_W'(1)) && (outer_left == CNT_W'(1));

  // Source pixel sits one shift behind the destination pixel.
  logic signed [SPAN_W-1:0] src_col_s;
  logic signed [SPAN_W-1:0] src_row_s;
  logic [COORD_W-1:0]       src_col;
  logic [COORD_W-1:0]       src_row;
  logic [PROD_W-1:0]        src_prod;
  logic [PROD_W-1:0]        dst_prod;
  logic [SUM_W-1:0]         src_sum;
  logic [SUM_W-1:0]         dst_sum;

  always_comb begin
    src_col_s = $signed({2'b00, dst_col}) - col_off;
    src_row_s = $signed({2'b00, dst_row}) - row_off;
    src_col   = src_col_s[COORD_W-1:0];
    src_row   = src_row_s[COORD_W-1:0];
    src_prod  = PROD_W'(src_row) * PROD_W'(stride_q);
    dst_prod  = PROD_W'(dst_row) * PROD_W'(stride_q);
    src_sum   = SUM_W'(src_prod) + SUM_W'(src_col[COORD_W-1:1]);
    dst_sum   = SUM_W'(dst_prod) + SUM_W'(dst_col[COORD_W-1:1]);
  end

  // Registered byte addresses and nibble selects of the current pixel.
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic              src_odd;
  logic              dst_odd;

  always_ff @(posedge clk) begin
    if (cmd.mv_addr) begin
      src_addr <= ADDR_W'(src_sum);
      dst_addr <= ADDR_W'(dst_sum);
      src_odd  <= src_col[0];
      dst_odd  <= dst_col[0];
    end
  end

  // Framebuffer memory and its port selection.
  logic [ADDR_W-1:0] bus_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [NIB_W-1:0]  src_nib;
  logic [DATA_W-1:0] merged;

  assign bus_addr  = ADDR_W'(byte_addr);
  assign ram_we    = cmd.bus_wr || cmd.mv_wr;
  assign ram_waddr = cmd.mv_wr ? dst_addr : bus_addr;
  assign ram_wdata = cmd.mv_wr ? merged : write_data;
  assign ram_raddr = cmd.mv_rsrc ? src_addr : (cmd.mv_rdst ? dst_addr : bus_addr);

  nfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FB_BYTES)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Capture the source nibble when the source byte returns.
  always_ff @(posedge clk) begin
    if (cmd.mv_rdst) begin
      src_nib <= src_odd ? NIB_W'(ram_rdata & NIB_LO_MASK)
                         : NIB_W'(ram_rdata >> NIB_SHIFT);
    end
  end

  // Place the source nibble into the returned destination byte.
  assign merged = dst_odd
                ? ((ram_rdata & NIB_HI_MASK) | DATA_W'(src_nib))
                : ((ram_rdata & NIB_LO_MASK) | (DATA_W'(src_nib) << NIB_SHIFT));

  // Result register toward the output channel.
  logic res_load;

  assign res_load = cmd.res_imm || cmd.res_rd || cmd.res_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_rd) begin
      read_data <= ram_rdata;
      op_done   <= 1'b1;
    end else if (cmd.res_mv) begin
      read_data <= '0;
      op_done   <= 1'b1;
    end else if (cmd.res_imm) begin
      read_data <= '0;
      op_done   <= cmd.res_imm_done;
    end
  end

  assign sts.out_valid = out_valid;
  assign sts.out_busy  = out_valid && out_stall;

  // Only one read source and one write source drive the memory per cycle.
  `NFB_ASSERT(a_one_read, $onehot0({cmd.bus_rd, cmd.mv_rsrc, cmd.mv_rdst}), "read conflict")
  `NFB_ASSERT(a_one_write, $onehot0({cmd.bus_wr, cmd.mv_wr}), "write conflict")

endmodule

`default_nettype wire
